// File: design/rer_pkg.sv
// Shared types and constants for the rail event recorder.
// No dependencies; imported by rer_counter_bank and rail_event_recorder.
package rer_pkg;

  // Rails handled by the block; the rail fields are a fixed six bits wide.
  localparam int unsigned RAIL_COUNT = 6;
  localparam int unsigned FIELD_W    = 6;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned KIND_COUNT = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned RAIL_SEL_W = 3;
  localparam int unsigned RAIL_IDX_W = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;

  localparam logic [FIELD_W-1:0] RAIL_MASK = FIELD_W'((64'd1 << RAIL_COUNT) - 64'd1);

  typedef enum logic [KIND_W-1:0] {
    CNT_BOOTS        = 2'd0,
    CNT_SHUTDOWNS    = 2'd1,
    CNT_OVERCURRENTS = 2'd2,
    CNT_OC_ENDS      = 2'd3
  } rer_kind_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } rer_op_e;

  // Input transfer, last field (opcode) in the lowest bits.
  typedef struct packed {
    logic [KIND_W-1:0]     counter_select;
    logic [RAIL_SEL_W-1:0] rail_index;
    logic [FIELD_W-1:0]    trip_flags;
    logic [FIELD_W-1:0]    pin_state;
    logic [FIELD_W-1:0]    rail_direction;
    logic                  opcode;
  } rer_in_t;

  // Result transfer, padded to three bytes.
  typedef struct packed {
    logic                  pad;
    logic                  recorded;
    logic [FIELD_W-1:0]    overcurrent_irq;
    logic [CNT_W-1:0]      read_value;
  } rer_out_t;

  // Per-kind rail masks of counters to bump this cycle.
  typedef struct packed {
    logic [FIELD_W-1:0] oc_ends;
    logic [FIELD_W-1:0] overcurrents;
    logic [FIELD_W-1:0] shutdowns;
    logic [FIELD_W-1:0] boots;
  } rer_bump_t;

endpackage

// File: design/rer_counter_bank.sv
// Event counter bank: four wrapping counters per rail, with one read port.
// Depends on rer_pkg.
module rer_counter_bank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rer_pkg::rer_bump_t             bump_i,
  input  logic [rer_pkg::RAIL_SEL_W-1:0] rd_rail_i,
  input  logic [rer_pkg::KIND_W-1:0]     rd_sel_i,
  output logic [rer_pkg::CNT_W-1:0]      rd_value_o
);
  import rer_pkg::*;

  logic [RAIL_COUNT-1:0][KIND_COUNT-1:0][CNT_W-1:0] cnt_q;
  logic [KIND_COUNT-1:0][RAIL_COUNT-1:0]            hit;

  always_comb begin
    hit[CNT_BOOTS]        = RAIL_COUNT'(bump_i.boots);
    hit[CNT_SHUTDOWNS]    = RAIL_COUNT'(bump_i.shutdowns);
    hit[CNT_OVERCURRENTS] = RAIL_COUNT'(bump_i.overcurrents);
    hit[CNT_OC_ENDS]      = RAIL_COUNT'(bump_i.oc_ends);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      for (int r = 0; r < RAIL_COUNT; r++) begin
        for (int k = 0; k < KIND_COUNT; k++) begin
          if (hit[k][r]) begin
            cnt_q[r][k] <= cnt_q[r][k] + CNT_W'(1);
          end
        end
      end
    end
  end

  // Out-of-range rails read as zero.
  always_comb begin
    rd_value_o = '0;
    if ({1'b0, rd_rail_i} < (RAIL_SEL_W + 1)'(RAIL_COUNT)) begin
      rd_value_o = cnt_q[rd_rail_i[RAIL_IDX_W-1:0]][rd_sel_i];
    end
  end

endmodule

// File: design/rail_event_recorder.sv
// Rail event recorder top level: stream ports, rail state and result register.
// Depends on rer_pkg and rer_counter_bank.
//
// Records power-rail events for six rails. Each input transfer either samples
// the rails (opcode 0) or reads one of the four 16-bit wrapping counters kept
// per rail (boots, shutdowns, overcurrents, overcurrent ends; opcode 1). Every
// input transfer yields exactly one result transfer, in order. A sample latches
// pin state and trip flags only while some rail is activated (direction bit
// low); it is recorded, bumping the counters and reporting the overcurrent
// interrupt bits, when the latched pins or the activated set changed or the
// latched trip flags are nonzero. A read of a rail index of six or more
// returns zero. Timing: an item is registered on acceptance and moves by one
// pass of logic into the result register when that register is free or being
// drained; the result is offered from the result register. One item is
// accepted per cycle while the output does not stall; the input register keeps
// accepting while a finished result waits, so a stalled output costs only when
// both stages are full.
module rail_event_recorder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] opcode, [6:1] rail_direction, [12:7] pin_state, [18:13] trip_flags,
  // [21:19] rail_index, [23:22] counter_select
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_value, [21:16] overcurrent_irq, [22] recorded, [23] zero
  output logic [23:0] m_axis_tdata
);
  import rer_pkg::*;

  // Input register stage.
  logic    in_valid_q;
  rer_in_t in_data_q;
  // Result register stage.
  logic     out_valid_q;
  rer_out_t out_data_q;
  rer_out_t res;

  // Rail history.
  logic [FIELD_W-1:0] prev_on_q, prev_on_d;
  logic [FIELD_W-1:0] prev_active_q, prev_active_d;
  logic [FIELD_W-1:0] held_on_q, held_on_d;
  logic [FIELD_W-1:0] held_flags_q, held_flags_d;

  logic               advance;
  logic               is_sample;
  logic               record;
  logic [FIELD_W-1:0] active;
  logic [FIELD_W-1:0] oc;
  logic [FIELD_W-1:0] ends;
  rer_bump_t          bump;
  logic [CNT_W-1:0]   rd_value;

  // Stage 1 moves on when the result register is free or being drained.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= rer_in_t'(s_axis_tdata);
    end
  end

  // Sample processing: latch, change detect, event masks.
  always_comb begin
    is_sample = advance & (in_data_q.opcode == OP_SAMPLE);
    active    = ~in_data_q.rail_direction & RAIL_MASK;

    held_on_d    = held_on_q;
    held_flags_d = held_flags_q;
    if (is_sample && (active != '0)) begin
      held_on_d    = in_data_q.pin_state & RAIL_MASK;
      held_flags_d = in_data_q.trip_flags & RAIL_MASK;
    end

    record = is_sample & ((held_on_d != prev_on_q) || (active != prev_active_q) ||
                          (held_flags_d != '0));

    oc   = ((~held_on_d & prev_on_q) | held_flags_d) & RAIL_MASK;
    ends = ((held_on_d & ~prev_on_q) | (held_flags_d & held_on_d)) & RAIL_MASK;

    bump = '0;
    if (record) begin
      bump.boots        = active & ~prev_active_q & RAIL_MASK;
      bump.shutdowns    = ~active & prev_active_q & RAIL_MASK;
      bump.overcurrents = oc;
      bump.oc_ends      = ends;
    end

    prev_on_d     = is_sample ? held_on_d : prev_on_q;
    prev_active_d = is_sample ? active : prev_active_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_on_q     <= '0;
      prev_active_q <= '0;
      held_on_q     <= '0;
      held_flags_q  <= '0;
    end else begin
      prev_on_q     <= prev_on_d;
      prev_active_q <= prev_active_d;
      held_on_q     <= held_on_d;
      held_flags_q  <= held_flags_d;
    end
  end

  rer_counter_bank u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bump_i     (bump),
    .rd_rail_i  (in_data_q.rail_index),
    .rd_sel_i   (in_data_q.counter_select),
    .rd_value_o (rd_value)
  );

  // Result assembly: reads see all earlier samples' updates.
  always_comb begin
    res                 = '0;
    res.read_value      = (in_data_q.opcode == OP_READ) ? rd_value : '0;
    res.overcurrent_irq = record ? oc : '0;
    res.recorded        = record;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

endmodule

// File: design/rer_checker.sv
// Port-level checks for the rail event recorder, bound to the top level.
// Depends on rail_event_recorder.
module rer_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Input side only stalls when a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Interrupt bits only on a recorded sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[22]) |-> (m_axis_tdata[21:16] == 6'd0))
    else $error("irq without recorded sample");

  // A nonzero read value comes from a read, which never records.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[15:0] != 16'd0)) |-> (m_axis_tdata[23:16] == 8'd0))
    else $error("read result carries sample flags");

  // Stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind rail_event_recorder rer_checker u_rer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/rer_checker.sv
// Scoreboard for the rail event recorder: watches both stream ports,
// predicts every result from its own rail state and counter bank, and compares.
// Depends on rer_pkg only.
module rer_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [0] opcode, [6:1] rail_direction, [12:7] pin_state, [18:13] trip_flags,
  // [21:19] rail_index, [23:22] counter_select
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_value, [21:16] overcurrent_irq, [22] recorded, [23] zero
  input  logic [23:0] m_axis_tdata,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned sample_count_o,
  output int unsigned recorded_count_o,
  output int unsigned read_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rer_pkg::*;

  // Shadow of the rail state and counter bank
  logic [FIELD_W-1:0] last_pins;
  logic [FIELD_W-1:0] last_active;
  logic [FIELD_W-1:0] kept_pins;
  logic [FIELD_W-1:0] kept_trips;
  logic [CNT_W-1:0]   tally [RAIL_COUNT][KIND_COUNT];

  rer_out_t    outstanding_results [$];
  rer_out_t    next_result;
  int unsigned fail_count;
  int unsigned sample_count;
  int unsigned recorded_count;
  int unsigned read_count;
  int unsigned pending;

  assign fail_count_o     = fail_count;
  assign pending_o        = pending;
  assign sample_count_o   = sample_count;
  assign recorded_count_o = recorded_count;
  assign read_count_o     = read_count;

  initial begin
    fail_count     = 0;
    sample_count   = 0;
    recorded_count = 0;
    read_count     = 0;
    pending        = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Result of one accepted item; updates the shadow state on samples.
  task automatic record_rail_item(input rer_in_t item, output rer_out_t res);
    logic [FIELD_W-1:0] active;
    logic [FIELD_W-1:0] bump [KIND_COUNT];
    res = '0;
    if (rer_op_e'(item.opcode) == OP_READ) begin
      read_count++;
      if (item.rail_index < RAIL_COUNT) begin
        res.read_value = tally[item.rail_index][item.counter_select];
      end
    end else begin
      sample_count++;
      active = ~item.rail_direction & RAIL_MASK;
      // pins and trips only latch while some rail is on
      if (active != '0) begin
        kept_pins  = item.pin_state & RAIL_MASK;
        kept_trips = item.trip_flags & RAIL_MASK;
      end
      if (kept_pins != last_pins || active != last_active || kept_trips != '0) begin
        bump[CNT_BOOTS]        = active & ~last_active & RAIL_MASK;
        bump[CNT_SHUTDOWNS]    = ~active & last_active & RAIL_MASK;
        bump[CNT_OVERCURRENTS] = ((~kept_pins & last_pins) | kept_trips) & RAIL_MASK;
        bump[CNT_OC_ENDS]      = ((kept_pins & ~last_pins) | (kept_trips & kept_pins))
                                 & RAIL_MASK;
        for (int r = 0; r < RAIL_COUNT; r++) begin
          for (int k = 0; k < KIND_COUNT; k++) begin
            if (bump[k][r]) tally[r][k] = tally[r][k] + CNT_W'(1);
          end
        end
        res.overcurrent_irq = bump[CNT_OVERCURRENTS];
        res.recorded        = 1'b1;
        recorded_count++;
      end
      last_pins   = kept_pins;
      last_active = active;
    end
  endtask

  task automatic check_result(input rer_out_t got);
    rer_out_t want;
    if (outstanding_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing outstanding", got));
      return;
    end
    want = outstanding_results.pop_front();
    if (got.read_value !== want.read_value)
      report_mismatch($sformatf("read_value %h, want %h", got.read_value, want.read_value));
    if (got.overcurrent_irq !== want.overcurrent_irq)
      report_mismatch($sformatf("overcurrent_irq %b, want %b",
                                got.overcurrent_irq, want.overcurrent_irq));
    if (got.recorded !== want.recorded)
      report_mismatch($sformatf("recorded %b, want %b", got.recorded, want.recorded));
    if (got.pad !== 1'b0)
      report_mismatch($sformatf("pad bit %b, want 0", got.pad));
  endtask

  // Sampled at the edge, before the block's own updates land
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins   = '0;
      last_active = '0;
      kept_pins   = '0;
      kept_trips  = '0;
      for (int r = 0; r < RAIL_COUNT; r++) begin
        for (int k = 0; k < KIND_COUNT; k++) tally[r][k] = '0;
      end
      outstanding_results.delete();
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(rer_out_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) begin
        record_rail_item(rer_in_t'(s_axis_tdata), next_result);
        outstanding_results.push_back(next_result);
      end
      pending = outstanding_results.size();
    end
  end

endmodule

// File: tb/tb_rail_event_recorder.sv
// Top-level bench for rail_event_recorder: clock, reset, stimulus and verdict.
// Depends on rer_pkg, rer_scoreboard and the rail_event_recorder RTL.
module tb_rail_event_recorder;
  timeunit 1ns;
  timeprecision 1ps;
  import rer_pkg::*;

  // Number of random transfers after the directed phase and the full readout
  localparam int unsigned RANDOM_ITEMS = 660;
  // Idle/stall odds in percent
  localparam int unsigned IDLE_PCT     = 18;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] opcode, [6:1] rail_direction, [12:7] pin_state, [18:13] trip_flags,
  // [21:19] rail_index, [23:22] counter_select
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] read_value, [21:16] overcurrent_irq, [22] recorded, [23] zero
  logic [23:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sample_count;
  int unsigned recorded_count;
  int unsigned read_count;

  // When set, neither side idles: long back-to-back stretch
  bit          calm = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rail_event_recorder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rer_scoreboard u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .sample_count_o   (sample_count),
    .recorded_count_o (recorded_count),
    .read_count_o     (read_count)
  );

  // Result sink: random backpressure, none while calm
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Sample item; the read-only fields carry noise the block must ignore
  function automatic rer_in_t rail_sample(input logic [FIELD_W-1:0] dir,
                                          input logic [FIELD_W-1:0] pins,
                                          input logic [FIELD_W-1:0] trips);
    rer_in_t item;
    item.opcode         = OP_SAMPLE;
    item.rail_direction = dir;
    item.pin_state      = pins;
    item.trip_flags     = trips;
    item.rail_index     = RAIL_SEL_W'($urandom);
    item.counter_select = KIND_W'($urandom);
    return item;
  endfunction

  // Counter read; the sample fields carry noise
  function automatic rer_in_t counter_read(input logic [RAIL_SEL_W-1:0] rail,
                                           input rer_kind_e kind);
    rer_in_t item;
    item.opcode         = OP_READ;
    item.rail_direction = FIELD_W'($urandom);
    item.pin_state      = FIELD_W'($urandom);
    item.trip_flags     = FIELD_W'($urandom);
    item.rail_index     = rail;
    item.counter_select = kind;
    return item;
  endfunction

  // One input transfer; optional idle cycles first, then hold until accepted.
  // tready is read right after the edge, so it is the pre-edge value.
  task automatic send_item(input rer_in_t item);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    logic [FIELD_W-1:0] dir;
    logic [FIELD_W-1:0] pins;
    logic [FIELD_W-1:0] trips;
    int unsigned        guard;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: activation, fall and rise of pins, trip flags, flags held
    // while every rail is off, relatch, then reads incl. bad rail indexes.
    send_item(counter_read(3'd0, CNT_BOOTS));
    send_item(rail_sample(6'h00, 6'h3F, 6'h00));  // all rails boot
    send_item(rail_sample(6'h00, 6'h3F, 6'h00));  // nothing changed
    send_item(rail_sample(6'h00, 6'h00, 6'h00));  // every pin drops
    send_item(rail_sample(6'h00, 6'h3F, 6'h3F));  // pins back, all tripped
    send_item(rail_sample(6'h3F, 6'h00, 6'h00));  // all off, flags stay latched
    send_item(rail_sample(6'h3F, 6'h15, 6'h2A));  // still off, still recorded
    send_item(rail_sample(6'h3E, 6'h3F, 6'h00));  // rail 0 on, flags cleared
    send_item(rail_sample(6'h3E, 6'h3F, 6'h00));  // steady again
    send_item(rail_sample(6'h2A, 6'h15, 6'h15));
    send_item(counter_read(3'd5, CNT_BOOTS));
    send_item(counter_read(3'd5, CNT_SHUTDOWNS));
    send_item(counter_read(3'd5, CNT_OVERCURRENTS));
    send_item(counter_read(3'd5, CNT_OC_ENDS));
    send_item(counter_read(3'd0, CNT_OC_ENDS));
    send_item(counter_read(3'd6, CNT_OVERCURRENTS));  // no such rail
    send_item(counter_read(3'd7, CNT_OC_ENDS));       // no such rail

    // Read back every counter of every rail
    for (int r = 0; r < RAIL_COUNT; r++) begin
      for (int k = 0; k < KIND_COUNT; k++) begin
        send_item(counter_read(RAIL_SEL_W'(r), rer_kind_e'(k)));
      end
    end

    // Random mix; repeated pins and zero trips keep many samples unrecorded
    pins = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 250 && i < 400);
      if ($urandom_range(0, 99) < 35) begin
        send_item(counter_read(RAIL_SEL_W'($urandom_range(0, 7)),
                               rer_kind_e'($urandom_range(0, 3))));
      end else begin
        case ($urandom_range(0, 3))
          0:       dir = 6'h3F;
          1:       dir = 6'h00;
          default: dir = FIELD_W'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0) pins = FIELD_W'($urandom);
        trips = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom) : '0;
        send_item(rail_sample(dir, pins, trips));
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then keep the clock running to catch any stray result
    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);

    $display("Covered %0d rail samples (%0d recorded) and %0d counter reads,",
             sample_count, recorded_count, read_count);
    $display("including a readout of every counter and reads of absent rails.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under 2 ms
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
